// File: rtl/jseu_pkg.sv
`timescale 1ns / 1ps

package jseu_pkg;

  // Most results one input transfer can cause: opening quote plus a \u00xx escape
  localparam int unsigned MaxResults = 7;
  localparam int unsigned CountW     = 3;

  // Error codes carried with the last result of a transfer
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_LEAD      = 2'd1,
    ERR_TRUNCATED = 2'd2,
    ERR_CONT      = 2'd3
  } err_t;

  // Input commands
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharU         = 8'h75;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] ContMin       = 8'h80;
  localparam logic [7:0] ContMax       = 8'hBF;

  // Results of one input transfer, first result in bytes[0]
  typedef struct packed {
    logic [CountW-1:0]           count;
    logic [MaxResults-1:0][7:0]  bytes;
    logic                        done;
    err_t                        err;
  } res_t;

  // Short escape letter, zero when the byte has none
  function automatic logic [7:0] short_escape(input logic [7:0] b);
    logic [7:0] e;
    case (b)
      8'h22:   e = CharQuote;
      8'h5C:   e = CharBackslash;
      8'h08:   e = 8'h62;  // b
      8'h0C:   e = 8'h66;  // f
      8'h0A:   e = 8'h6E;  // n
      8'h0D:   e = 8'h72;  // r
      8'h09:   e = 8'h74;  // t
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  // Lowercase hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

  // UTF-8 sequence length from lead byte, zero when the lead is invalid
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b >= 8'hC2 && b <= 8'hDF) begin
      len = 3'd2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      len = 3'd3;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Allowed range of the second byte, which rules out overlongs,
  // surrogates and code points above U+10FFFF
  function automatic logic [7:0] second_lower_bound(input logic [7:0] b);
    logic [7:0] lo;
    case (b)
      8'hE0:   lo = 8'hA0;
      8'hF0:   lo = 8'h90;
      default: lo = ContMin;
    endcase
    return lo;
  endfunction

  function automatic logic [7:0] second_upper_bound(input logic [7:0] b);
    logic [7:0] hi;
    case (b)
      8'hED:   hi = 8'h9F;
      8'hF4:   hi = 8'h8F;
      default: hi = ContMax;
    endcase
    return hi;
  endfunction

endpackage

// File: rtl/jseu_core.sv
`timescale 1ns / 1ps

module jseu_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                command,
  input  logic [7:0]          in_byte,
  output jseu_pkg::res_t      res
);

  logic             string_open, string_open_next;
  logic             rejected, rejected_next;
  logic [1:0]       held_count, held_count_next;
  logic [2:0][7:0]  held_bytes, held_bytes_next;
  logic [2:0]       sequence_length, sequence_length_next;
  logic [7:0]       second_min, second_min_next;
  logic [7:0]       second_max, second_max_next;

  // Result list and next state for the item at the input
  always_comb begin
    logic [2:0] k;
    logic [7:0] esc;
    logic [2:0] len;
    logic       bad;

    string_open_next     = string_open;
    rejected_next        = rejected;
    held_count_next      = held_count;
    held_bytes_next      = held_bytes;
    sequence_length_next = sequence_length;
    second_min_next      = second_min;
    second_max_next      = second_max;
    res                  = '0;
    res.err              = jseu_pkg::ERR_NONE;
    k                    = '0;
    esc                  = jseu_pkg::short_escape(in_byte);
    len                  = jseu_pkg::lead_length(in_byte);
    bad                  = 1'b0;

    if (command == jseu_pkg::CMD_DATA) begin
      if (!rejected) begin
        if (!string_open) begin
          res.bytes[k] = jseu_pkg::CharQuote;
          k = k + 3'd1;
          string_open_next = 1'b1;
        end
        if (held_count == 2'd0) begin
          if (!in_byte[7]) begin
            // plain ASCII, escaped where JSON needs it
            if (esc != 8'h00) begin
              res.bytes[k] = jseu_pkg::CharBackslash;
              k = k + 3'd1;
              res.bytes[k] = esc;
              k = k + 3'd1;
            end else if (in_byte < 8'h20) begin
              res.bytes[k] = jseu_pkg::CharBackslash;
              k = k + 3'd1;
              res.bytes[k] = jseu_pkg::CharU;
              k = k + 3'd1;
              res.bytes[k] = jseu_pkg::CharZero;
              k = k + 3'd1;
              res.bytes[k] = jseu_pkg::CharZero;
              k = k + 3'd1;
              res.bytes[k] = jseu_pkg::hex_digit(in_byte[7:4]);
              k = k + 3'd1;
              res.bytes[k] = jseu_pkg::hex_digit(in_byte[3:0]);
              k = k + 3'd1;
            end else begin
              res.bytes[k] = in_byte;
              k = k + 3'd1;
            end
          end else if (len == 3'd0) begin
            res.bytes[k] = 8'h00;
            k = k + 3'd1;
            res.done = 1'b1;
            res.err = jseu_pkg::ERR_LEAD;
            rejected_next = 1'b1;
          end else begin
            // lead byte: hold it until the sequence is complete
            held_bytes_next[0]   = in_byte;
            held_count_next      = 2'd1;
            sequence_length_next = len;
            second_min_next      = jseu_pkg::second_lower_bound(in_byte);
            second_max_next      = jseu_pkg::second_upper_bound(in_byte);
          end
        end else begin
          if (held_count == 2'd1) begin
            bad = (in_byte < second_min) || (in_byte > second_max);
          end else begin
            bad = (in_byte[7:6] != 2'b10);
          end
          if (bad) begin
            res.bytes[k] = 8'h00;
            k = k + 3'd1;
            res.done = 1'b1;
            res.err = jseu_pkg::ERR_CONT;
            rejected_next = 1'b1;
            held_count_next = 2'd0;
            sequence_length_next = 3'd0;
            second_min_next = jseu_pkg::ContMin;
            second_max_next = jseu_pkg::ContMax;
          end else if ({1'b0, held_count} + 3'd1 >= sequence_length) begin
            // sequence complete: release held bytes and this one
            for (int j = 0; j < 3; j++) begin
              if (j < int'(held_count)) begin
                res.bytes[k] = held_bytes[j];
                k = k + 3'd1;
              end
            end
            res.bytes[k] = in_byte;
            k = k + 3'd1;
            held_count_next = 2'd0;
            sequence_length_next = 3'd0;
            second_min_next = jseu_pkg::ContMin;
            second_max_next = jseu_pkg::ContMax;
          end else begin
            held_bytes_next[held_count] = in_byte;
            held_count_next = held_count + 2'd1;
          end
        end
      end
    end else begin
      // end of string
      if (!rejected) begin
        if (held_count != 2'd0) begin
          res.bytes[k] = 8'h00;
          k = k + 3'd1;
          res.done = 1'b1;
          res.err = jseu_pkg::ERR_TRUNCATED;
        end else begin
          if (!string_open) begin
            res.bytes[k] = jseu_pkg::CharQuote;
            k = k + 3'd1;
          end
          res.bytes[k] = jseu_pkg::CharQuote;
          k = k + 3'd1;
          res.done = 1'b1;
        end
      end
      string_open_next     = 1'b0;
      rejected_next        = 1'b0;
      held_count_next      = 2'd0;
      sequence_length_next = 3'd0;
      second_min_next      = jseu_pkg::ContMin;
      second_max_next      = jseu_pkg::ContMax;
    end
    res.count = k;
  end

  // String state
  always_ff @(posedge clk) begin
    if (rst) begin
      string_open     <= 1'b0;
      rejected        <= 1'b0;
      held_count      <= 2'd0;
      sequence_length <= 3'd0;
      second_min      <= jseu_pkg::ContMin;
      second_max      <= jseu_pkg::ContMax;
    end else if (accept) begin
      string_open     <= string_open_next;
      rejected        <= rejected_next;
      held_count      <= held_count_next;
      sequence_length <= sequence_length_next;
      second_min      <= second_min_next;
      second_max      <= second_max_next;
    end
  end

  // Held sequence bytes, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

// File: rtl/jseu_out.sv
`timescale 1ns / 1ps

module jseu_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jseu_pkg::res_t  res,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic [2:0]      m_tuser
);

  logic [jseu_pkg::MaxResults-1:0][7:0] buffer;
  logic [jseu_pkg::CountW-1:0]          last_idx;
  logic [jseu_pkg::CountW-1:0]          ptr;
  logic                                 last_done;
  jseu_pkg::err_t                       last_err;
  logic                                 valid;

  // Control: run through the buffered results one transfer at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ptr   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      ptr   <= '0;
    end else if (valid && m_tready) begin
      if (ptr == last_idx) begin
        valid <= 1'b0;
      end else begin
        ptr <= ptr + 3'd1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      buffer    <= res.bytes;
      last_idx  <= res.count - 3'd1;
      last_done <= res.done;
      last_err  <= res.err;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = buffer[ptr];
  assign m_tlast  = (ptr == last_idx);
  assign m_tuser  = m_tlast ? {last_err, last_done} : 3'd0;

endmodule

// File: rtl/json_string_escape_utf8_check_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                              Contents
// s_       in   s_tvalid s_tready s_tdata s_tuser    in_byte; command
// m_       out  m_tvalid m_tready m_tdata m_tlast    out_byte; run_last
//                         m_tuser                    string_done, error_code
//
// The escape and UTF-8 checks of an input transfer run in the cycle it is
// accepted and load any results, up to seven bytes, into the result buffer.
// The output side sends one result per cycle while m_tready is high; an item
// holds the input until its last result is sent, and the next item is taken with it.
// Reset (rst, synchronous) empties the buffer and returns to the idle state.
module json_string_escape_utf8_check_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // [0] command
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [2:0] m_tuser    // [0] string_done, [2:1] error_code
);

  jseu_pkg::res_t res;
  logic           accept;

  // Take a new item once the buffer is empty or its last result leaves
  assign s_tready = !m_tvalid || (m_tready && m_tlast);
  assign accept   = s_tvalid && s_tready;

  jseu_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (s_tuser),
    .in_byte (s_tdata),
    .res     (res)
  );

  jseu_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && (res.count != 3'd0)),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int RandItems = 240;

  // One output transfer as the checker sees it
  typedef struct {
    logic [7:0]     data;
    logic           last;
    logic           done;
    jseu_pkg::err_t err;
  } char_res_t;

  // One stimulus row; typed rows carry their expected results directly
  typedef struct {
    logic           cmd;
    logic [7:0]     data;
    bit             typed;
    int             n;
    logic [7:0]     first_byte;
    logic [7:0]     last_byte;
    logic           done;
    jseu_pkg::err_t err;
  } stim_row_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_tuser  = 1'b0;   // [0] command
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;
  logic [2:0] m_tuser;           // [0] string_done, [2:1] error_code

  stim_row_t  stim_rows[$];
  char_res_t  expected_chars[$];
  char_res_t  step_out[$];
  int         errors    = 0;
  bit         src_burst = 1'b0;
  bit         snk_burst = 1'b0;

  // Escaper state
  logic       str_open     = 1'b0;
  logic       str_rejected = 1'b0;
  logic [1:0] pend_count   = 2'd0;
  logic [7:0] pend_bytes[3];
  logic [2:0] pend_len     = 3'd0;
  logic [7:0] sec_lo       = 8'h80;
  logic [7:0] sec_hi       = 8'hBF;

  always #6 clk = ~clk;

  json_string_escape_utf8_check_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Length of a UTF-8 sequence from its lead, with the legal second-byte range
  function automatic logic [2:0] seq_length(input logic [7:0] b, output logic [7:0] lo,
                                            output logic [7:0] hi);
    logic [2:0] len;
    lo  = 8'h80;
    hi  = 8'hBF;
    len = 3'd0;
    if (b >= 8'hC2 && b <= 8'hDF) begin
      len = 3'd2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      len = 3'd3;
      if (b == 8'hE0) lo = 8'hA0;
      if (b == 8'hED) hi = 8'h9F;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      len = 3'd4;
      if (b == 8'hF0) lo = 8'h90;
      if (b == 8'hF4) hi = 8'h8F;
    end
    return len;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + 8'(d)) : (8'h61 + 8'(d) - 8'd10);
  endfunction

  function automatic void push_char(input logic [7:0] d, input logic dn,
                                    input jseu_pkg::err_t e);
    char_res_t r;
    r.data = d;
    r.last = 1'b0;
    r.done = dn;
    r.err  = e;
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic void clear_seq();
    pend_count = 2'd0;
    pend_len   = 3'd0;
    sec_lo     = 8'h80;
    sec_hi     = 8'hBF;
  endfunction

  function automatic void reject(input jseu_pkg::err_t e);
    push_char(8'h00, 1'b1, e);
    str_rejected = 1'b1;
    clear_seq();
  endfunction

  // One data byte of an open string
  function automatic void predict_byte(input logic [7:0] b);
    logic [7:0] esc;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [2:0] len;
    if (pend_count == 2'd0) begin
      if (b < 8'h80) begin
        esc = 8'h00;
        case (b)
          8'h22:   esc = jseu_pkg::CharQuote;
          8'h5C:   esc = jseu_pkg::CharBackslash;
          8'h08:   esc = "b";
          8'h09:   esc = "t";
          8'h0A:   esc = "n";
          8'h0C:   esc = "f";
          8'h0D:   esc = "r";
          default: esc = 8'h00;
        endcase
        if (esc != 8'h00) begin
          push_char(jseu_pkg::CharBackslash, 1'b0, jseu_pkg::ERR_NONE);
          push_char(esc, 1'b0, jseu_pkg::ERR_NONE);
        end else if (b < 8'h20) begin
          push_char(jseu_pkg::CharBackslash, 1'b0, jseu_pkg::ERR_NONE);
          push_char("u", 1'b0, jseu_pkg::ERR_NONE);
          push_char("0", 1'b0, jseu_pkg::ERR_NONE);
          push_char("0", 1'b0, jseu_pkg::ERR_NONE);
          push_char(hex_char(b[7:4]), 1'b0, jseu_pkg::ERR_NONE);
          push_char(hex_char(b[3:0]), 1'b0, jseu_pkg::ERR_NONE);
        end else begin
          push_char(b, 1'b0, jseu_pkg::ERR_NONE);
        end
        return;
      end
      len = seq_length(b, lo, hi);
      if (len == 3'd0) begin
        reject(jseu_pkg::ERR_LEAD);
        return;
      end
      pend_bytes[0] = b;
      pend_count    = 2'd1;
      pend_len      = len;
      sec_lo        = lo;
      sec_hi        = hi;
      return;
    end
    // second byte has a lead-specific range, later ones are plain continuations
    if ((pend_count == 2'd1) ? (b < sec_lo || b > sec_hi) : (b[7:6] != 2'b10)) begin
      reject(jseu_pkg::ERR_CONT);
      return;
    end
    if (int'(pend_count) + 1 >= int'(pend_len)) begin
      for (int k = 0; k < int'(pend_count); k++) begin
        push_char(pend_bytes[k], 1'b0, jseu_pkg::ERR_NONE);
      end
      push_char(b, 1'b0, jseu_pkg::ERR_NONE);
      clear_seq();
    end else begin
      pend_bytes[pend_count] = b;
      pend_count = pend_count + 2'd1;
    end
  endfunction

  // Results of one accepted input transfer, left in step_out
  function automatic void predict_step(input logic cmd, input logic [7:0] b);
    step_out.delete();
    if (cmd == jseu_pkg::CMD_DATA) begin
      if (!str_rejected) begin
        if (!str_open) begin
          push_char(jseu_pkg::CharQuote, 1'b0, jseu_pkg::ERR_NONE);
          str_open = 1'b1;
        end
        predict_byte(b);
      end
    end else begin
      if (!str_rejected) begin
        if (pend_count != 2'd0) begin
          push_char(8'h00, 1'b1, jseu_pkg::ERR_TRUNCATED);
        end else begin
          if (!str_open) push_char(jseu_pkg::CharQuote, 1'b0, jseu_pkg::ERR_NONE);
          push_char(jseu_pkg::CharQuote, 1'b1, jseu_pkg::ERR_NONE);
        end
      end
      str_open     = 1'b0;
      str_rejected = 1'b0;
      clear_seq();
    end
    if (step_out.size() > 0) begin
      step_out[step_out.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void add_row(input logic cmd, input logic [7:0] d);
    stim_row_t row;
    row       = '{cmd, d, 1'b0, 0, 8'h00, 8'h00, 1'b0, jseu_pkg::ERR_NONE};
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // n results; with two, the first is plain and the last carries done/err
  function automatic void add_checked(input logic cmd, input logic [7:0] d, input int n,
                                      input logic [7:0] fb, input logic [7:0] lb,
                                      input logic dn, input jseu_pkg::err_t e);
    stim_row_t row;
    row = '{cmd, d, 1'b1, n, fb, lb, dn, e};
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // A random string: mostly well-formed characters, some near misses and noise
  function automatic void add_random_string();
    int         segs;
    int         kind;
    int         len;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    segs = $urandom_range(0, 7);
    repeat (segs) begin
      kind = $urandom_range(0, 15);
      if (kind < 4) begin
        add_row(jseu_pkg::CMD_DATA, 8'($urandom_range(8'h20, 8'h7F)));
      end else if (kind < 6) begin
        add_row(jseu_pkg::CMD_DATA, 8'($urandom_range(8'h00, 8'h1F)));
      end else if (kind == 6) begin
        add_row(jseu_pkg::CMD_DATA, ($urandom_range(0, 1) != 0) ?
                jseu_pkg::CharQuote : jseu_pkg::CharBackslash);
      end else if (kind < 12) begin
        // well-formed multi-byte character, now and then cut short
        lead = 8'($urandom_range(8'hC2, 8'hF4));
        len  = int'(seq_length(lead, lo, hi));
        add_row(jseu_pkg::CMD_DATA, lead);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
        for (int k = 1; k < len; k++) begin
          if (k == 1) add_row(jseu_pkg::CMD_DATA, 8'($urandom_range(lo, hi)));
          else add_row(jseu_pkg::CMD_DATA, 8'($urandom_range(8'h80, 8'hBF)));
        end
      end else if (kind < 14) begin
        // lead from the top quarter with bytes around the continuation range
        add_row(jseu_pkg::CMD_DATA, 8'($urandom_range(8'hC0, 8'hFF)));
        repeat ($urandom_range(1, 3)) begin
          add_row(jseu_pkg::CMD_DATA, 8'($urandom_range(8'h70, 8'hC8)));
        end
      end else begin
        add_row(jseu_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
      end
    end
    add_row(jseu_pkg::CMD_END, 8'($urandom_range(0, 255)));
  endfunction

  function automatic int pick_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %02h, got %02h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Drive one row from a falling edge, wait for its transfer, book its results
  task automatic send_row(input stim_row_t row);
    int        gap;
    char_res_t r;
    gap = pick_gap(src_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.cmd;
    s_tdata  <= row.data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_step(row.cmd, row.data);
    if (row.typed) begin
      if (row.n == 2) begin
        r = '{row.first_byte, 1'b0, 1'b0, jseu_pkg::ERR_NONE};
        expected_chars.insert(expected_chars.size(), r);
      end
      if (row.n >= 1) begin
        r = '{row.last_byte, 1'b1, row.done, row.err};
        expected_chars.insert(expected_chars.size(), r);
      end
    end else begin
      foreach (step_out[k]) expected_chars.insert(expected_chars.size(), step_out[k]);
    end
    @(negedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    int n_directed;
    // empty string; the byte of an end command is ignored
    add_checked(jseu_pkg::CMD_END, 8'hA5, 2, jseu_pkg::CharQuote, jseu_pkg::CharQuote,
                1'b1, jseu_pkg::ERR_NONE);
    // control bytes, short escapes and plain extremes
    add_row(jseu_pkg::CMD_DATA, 8'h00);
    add_row(jseu_pkg::CMD_DATA, 8'h1F);
    add_row(jseu_pkg::CMD_DATA, 8'h22);
    add_row(jseu_pkg::CMD_DATA, 8'h5C);
    add_row(jseu_pkg::CMD_DATA, 8'h08);
    add_row(jseu_pkg::CMD_DATA, 8'h09);
    add_row(jseu_pkg::CMD_DATA, 8'h0A);
    add_row(jseu_pkg::CMD_DATA, 8'h0C);
    add_row(jseu_pkg::CMD_DATA, 8'h0D);
    add_row(jseu_pkg::CMD_DATA, 8'h7F);
    // lowest two-byte and highest four-byte characters
    add_row(jseu_pkg::CMD_DATA, 8'hC2);
    add_checked(jseu_pkg::CMD_DATA, 8'h80, 2, 8'hC2, 8'h80, 1'b0, jseu_pkg::ERR_NONE);
    add_row(jseu_pkg::CMD_DATA, 8'hF4);
    add_row(jseu_pkg::CMD_DATA, 8'h8F);
    add_row(jseu_pkg::CMD_DATA, 8'hBF);
    add_row(jseu_pkg::CMD_DATA, 8'hBF);
    add_checked(jseu_pkg::CMD_END, 8'h00, 1, 8'h00, jseu_pkg::CharQuote, 1'b1,
                jseu_pkg::ERR_NONE);
    // overlong three-byte form as the first byte, then data and end while rejected
    add_checked(jseu_pkg::CMD_DATA, 8'hE0, 1, 8'h00, jseu_pkg::CharQuote, 1'b0,
                jseu_pkg::ERR_NONE);
    add_checked(jseu_pkg::CMD_DATA, 8'h9F, 1, 8'h00, 8'h00, 1'b1, jseu_pkg::ERR_CONT);
    add_checked(jseu_pkg::CMD_DATA, 8'h41, 0, 8'h00, 8'h00, 1'b0, jseu_pkg::ERR_NONE);
    add_checked(jseu_pkg::CMD_END, 8'hFF, 0, 8'h00, 8'h00, 1'b0, jseu_pkg::ERR_NONE);
    // invalid lead as the first byte: quote, then the error
    add_checked(jseu_pkg::CMD_DATA, 8'hFF, 2, jseu_pkg::CharQuote, 8'h00, 1'b1,
                jseu_pkg::ERR_LEAD);
    add_checked(jseu_pkg::CMD_END, 8'h00, 0, 8'h00, 8'h00, 1'b0, jseu_pkg::ERR_NONE);
    // end while a sequence is pending
    add_checked(jseu_pkg::CMD_DATA, 8'hED, 1, 8'h00, jseu_pkg::CharQuote, 1'b0,
                jseu_pkg::ERR_NONE);
    add_checked(jseu_pkg::CMD_END, 8'h00, 1, 8'h00, 8'h00, 1'b1, jseu_pkg::ERR_TRUNCATED);
    // lone continuation byte
    add_checked(jseu_pkg::CMD_DATA, 8'h80, 2, jseu_pkg::CharQuote, 8'h00, 1'b1,
                jseu_pkg::ERR_LEAD);
    add_checked(jseu_pkg::CMD_END, 8'h00, 0, 8'h00, 8'h00, 1'b0, jseu_pkg::ERR_NONE);

    n_directed = stim_rows.size();
    while (stim_rows.size() < n_directed + RandItems) add_random_string();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if ($urandom_range(0, 29) == 0) src_burst = !src_burst;
      send_row(stim_rows[i]);
    end
    s_tvalid <= 1'b0;

    // drain, then watch for stray results
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("** json_string_escape_utf8_check_unit: PASSED **");
    end else begin
      $display("** json_string_escape_utf8_check_unit: FAILED **");
    end
    $finish;
  end

  // Output side: random stalls, each transfer checked against the oldest expectation
  initial begin
    int        gap;
    char_res_t want;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) snk_burst = !snk_burst;
      gap = pick_gap(snk_burst);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, got out_byte %02h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        check_field("out_byte", want.data, m_tdata);
        check_field("run_last", 8'(want.last), 8'(m_tlast));
        check_field("string_done", 8'(want.done), 8'(m_tuser[0]));
        check_field("error_code", 8'(want.err), 8'(m_tuser[2:1]));
      end
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** json_string_escape_utf8_check_unit: FAILED **");
    $finish;
  end

endmodule
